>>> hdl/rsput_pkg.sv
// Package for the range-sum / point-update tree.
// Holds sizes, the command codes and the result struct; no dependencies.
`default_nettype none
package rsput_pkg;
    localparam int LEAVES  = 1024;
    localparam int IDX_W   = 10;
    localparam int DATA_W  = 32;
    localparam int DEPTH   = 2 * LEAVES;
    localparam int NODE_AW = $clog2(DEPTH);
    localparam int WALK_W  = NODE_AW + 1;
    localparam int CMP_W   = ((WALK_W > IDX_W) ? WALK_W : IDX_W) + 1;

    typedef enum logic {
        CMD_SET   = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef logic [NODE_AW-1:0] t_node;
    typedef logic [WALK_W-1:0]  t_walk;
    typedef logic [CMP_W-1:0]   t_cmp;
    typedef logic [DATA_W-1:0]  t_word;

    typedef struct packed {
        logic  valid;
        t_word sum;
    } t_result;
endpackage
`default_nettype wire

>>> hdl/rsput_if.sv
// Channel interfaces for the range-sum tree: item input and sum output.
// Depends on rsput_pkg.
`default_nettype none
interface rsput_in_if import rsput_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [0:0]               cmd;
    logic [IDX_W-1:0]         first_index;
    logic [IDX_W-1:0]         last_index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, cmd, first_index, last_index, value, input ready);
    modport sink   (input valid, cmd, first_index, last_index, value, output ready);
endinterface

interface rsput_out_if import rsput_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_sum;

    modport source (output valid, range_sum, input ready);
    modport sink   (input valid, range_sum, output ready);
endinterface
`default_nettype wire

>>> hdl/rsput_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module rsput_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic      [WIDTH-1:0]         o_rdata0,
    output logic      [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule
`default_nettype wire

>>> hdl/rsput_engine.sv
// Tree walker: clearing sweep, leaf update up to the root, range query walk.
// Depends on rsput_pkg, rsput_if and rsput_ram.
`default_nettype none
module rsput_engine import rsput_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsput_in_if.sink   i_in,
    input  wire logic  i_res_free,
    output t_result    o_res
);
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SET_LEAF,
        S_SET_UP,
        S_QUERY,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_node  r_clr, n_clr;
    t_node  r_k, n_k;
    t_word  r_cur, n_cur;
    t_walk  r_a, n_a;
    t_walk  r_b, n_b;
    logic   r_fa, n_fa;
    logic   r_fb, n_fb;
    t_word  r_acc, n_acc;

    logic   w_we;
    t_node  w_waddr;
    t_word  w_wdata;
    t_node  w_ra0;
    t_node  w_ra1;
    t_word  w_rd0;
    t_word  w_rd1;
    t_word  w_term_a;
    t_word  w_term_b;
    t_node  w_parent;
    t_word  w_up_sum;
    t_cmp   w_first;
    t_cmp   w_last;
    t_cmp   w_hi;
    logic   w_accept;

    rsput_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_waddr),
        .i_wdata  (w_wdata),
        .i_raddr0 (w_ra0),
        .i_raddr1 (w_ra1),
        .o_rdata0 (w_rd0),
        .o_rdata1 (w_rd1)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);

    assign o_res.valid = (r_state == S_EMIT);
    assign o_res.sum   = r_acc;

    assign w_term_a = r_fa ? w_rd0 : '0;
    assign w_term_b = r_fb ? w_rd1 : '0;
    assign w_parent = r_k >> 1;
    assign w_up_sum = r_cur + w_rd0;

    assign w_first = t_cmp'(i_in.first_index);
    assign w_last  = t_cmp'(i_in.last_index);
    assign w_hi    = (w_last >= t_cmp'(LEAVES)) ? t_cmp'(LEAVES - 1) : w_last;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_k     = r_k;
        n_cur   = r_cur;
        n_a     = r_a;
        n_b     = r_b;
        n_fa    = r_fa;
        n_fb    = r_fb;
        n_acc   = r_acc;
        w_we    = 1'b0;
        w_waddr = r_k;
        w_wdata = r_cur;
        w_ra0   = r_k ^ t_node'(1);
        w_ra1   = t_node'(r_b - t_walk'(1));
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + t_node'(1);
                if (r_clr == t_node'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.cmd == CMD_QUERY) begin
                        n_acc   = '0;
                        n_fa    = 1'b0;
                        n_fb    = 1'b0;
                        n_state = S_QUERY;
                        if (w_first >= t_cmp'(LEAVES)) begin
                            n_a = '0;
                            n_b = '0;
                        end else begin
                            n_a = t_walk'(w_first + t_cmp'(LEAVES));
                            n_b = t_walk'(w_hi + t_cmp'(LEAVES) + t_cmp'(1));
                        end
                    end else if (w_first < t_cmp'(LEAVES)) begin
                        n_k     = t_node'(w_first + t_cmp'(LEAVES));
                        n_cur   = i_in.value;
                        n_state = S_SET_LEAF;
                    end
                end
            end
            S_SET_LEAF: begin
                w_we    = 1'b1;
                n_state = S_SET_UP;
            end
            S_SET_UP: begin
                w_we    = 1'b1;
                w_waddr = w_parent;
                w_wdata = w_up_sum;
                w_ra0   = w_parent ^ t_node'(1);
                n_k     = w_parent;
                n_cur   = w_up_sum;
                if (w_parent == t_node'(1)) begin
                    n_state = S_IDLE;
                end
            end
            S_QUERY: begin
                n_acc = r_acc + w_term_a + w_term_b;
                w_ra0 = t_node'(r_a);
                if (r_a < r_b) begin
                    n_fa = r_a[0];
                    n_fb = r_b[0];
                    n_a  = (r_a + t_walk'(r_a[0])) >> 1;
                    n_b  = (r_b - t_walk'(r_b[0])) >> 1;
                end else begin
                    n_fa    = 1'b0;
                    n_fb    = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_fa    <= 1'b0;
            r_fb    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_fa    <= n_fa;
            r_fb    <= n_fb;
        end
        r_k   <= n_k;
        r_cur <= n_cur;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
    end
endmodule
`default_nettype wire

>>> hdl/range_sum_point_update_tree.sv
// Channel  Dir  Payload                                  Beat when
// i_in     in   cmd, first_index, last_index, value      i_in.valid && i_in.ready
// o_out    out  range_sum (one beat per query)           o_out.valid && o_out.ready
//
// A set beat writes the leaf and then each parent up to the root, one tree level per
// cycle through the single write port of the node RAM. A query beat walks one level
// per cycle over the two RAM read ports. After reset a clearing sweep writes all
// 2*LEAVES nodes to zero, with i_in.ready low. A finished sum waits in the output
// register while the next beat is taken; a query result holds in the walker while
// that register is full and o_out.ready is low.
// Top level of the range-sum tree. Depends on rsput_pkg, rsput_if, rsput_engine.
`default_nettype none
module range_sum_point_update_tree import rsput_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rsput_in_if.sink   i_in,
    rsput_out_if.source o_out
);
    t_result w_res;
    logic    w_res_free;
    logic    r_out_valid;
    t_word   r_out_sum;

    assign w_res_free = !r_out_valid || o_out.ready;

    rsput_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_res_free (w_res_free),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_res_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res.valid && w_res_free) begin
            r_out_sum <= w_res.sum;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.range_sum = r_out_sum;
endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for range_sum_point_update_tree: random and directed set/query beats.
// Uses a scoreboard class that keeps its own sum tree. Depends on rsput_pkg, rsput_if
// and the top level of the block.
`timescale 1ns / 1ps
module tb;
    import rsput_pkg::*;

    class sum_board;
        logic [DATA_W-1:0] nodes [DEPTH];
        logic [DATA_W-1:0] sums_due [$];
        int                failures;
        int                reported;

        function new();
            foreach (nodes[k]) nodes[k] = '0;
            failures = 0;
            reported = 0;
        endfunction

        function void note_item(t_cmd cmd, logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
                                logic [DATA_W-1:0] value);
            int unsigned       k;
            int unsigned       lo;
            int unsigned       hi;
            logic [DATA_W-1:0] acc;
            lo  = int'(first);
            hi  = int'(last);
            acc = '0;
            if (cmd == CMD_SET) begin
                if (lo < LEAVES) begin
                    k = lo + LEAVES;
                    nodes[k] = value;
                    while (k > 1) begin
                        k = k >> 1;
                        nodes[k] = nodes[2 * k] + nodes[2 * k + 1];
                    end
                end
            end else begin
                if (hi >= LEAVES) hi = LEAVES - 1;
                if (lo < LEAVES && lo <= hi) begin
                    lo = lo + LEAVES;
                    hi = hi + LEAVES + 1;
                    while (lo < hi) begin
                        if (lo[0]) begin
                            acc = acc + nodes[lo];
                            lo  = lo + 1;
                        end
                        if (hi[0]) begin
                            hi  = hi - 1;
                            acc = acc + nodes[hi];
                        end
                        lo = lo >> 1;
                        hi = hi >> 1;
                    end
                end
                sums_due = {sums_due, acc};
            end
        endfunction

        function void check_sum(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (sums_due.size() == 0) begin
                failures++;
                if (reported < 10) begin
                    reported++;
                    $display("%0t: unexpected range_sum beat %h", $time, got);
                end
            end else begin
                want = sums_due.pop_front();
                if (got !== want) begin
                    failures++;
                    if (reported < 10) begin
                        reported++;
                        $display("%0t: range_sum mismatch: expected %h, got %h",
                                 $time, want, got);
                    end
                end
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_request;

    sum_board board = new();

    rsput_in_if  in_ch();
    rsput_out_if out_ch();

    range_sum_point_update_tree DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("tb: FAIL");
        $finish;
    end

    function automatic int pick_index();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 31);
            1:       return $urandom_range(LEAVES - 32, LEAVES - 1);
            2:       return $urandom_range(500, 531);
            default: return $urandom_range(0, LEAVES - 1);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input t_cmd cmd, input int first, input int last,
                             input logic [DATA_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.first_index <= IDX_W'(first);
        in_ch.last_index  <= IDX_W'(last);
        in_ch.value       <= value;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        board.note_item(cmd, IDX_W'(first), IDX_W'(last), value);
    endtask

    task automatic random_query();
        int lo;
        int hi;
        lo = $urandom_range(0, LEAVES - 1);
        hi = $urandom_range(0, LEAVES - 1);
        case ($urandom_range(0, 5))
            1: begin
                lo = pick_index();
                hi = lo + $urandom_range(0, 15);
                if (hi > LEAVES - 1) hi = LEAVES - 1;
            end
            2: lo = 0;
            3: hi = LEAVES - 1;
            4: begin
                lo = pick_index();
                hi = lo;
            end
            5: begin
                lo = $urandom_range(1, LEAVES - 1);
                hi = $urandom_range(0, lo - 1);
            end
            default: ;
        endcase
        send_item(CMD_QUERY, lo, hi, pick_value());
    endtask

    task automatic random_phase(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            if ($urandom_range(0, 99) < 45)
                send_item(CMD_SET, pick_index(), $urandom_range(0, LEAVES - 1), pick_value());
            else
                random_query();
        end
    endtask

    initial begin
        int hold_len;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_len     = hold_request;
                hold_request = 0;
                repeat (hold_len) begin
                    out_ch.ready <= 1'b0;
                    @(negedge clk);
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) board.check_sum(out_ch.range_sum);
    end

    initial begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.cmd         = CMD_SET;
        in_ch.first_index = '0;
        in_ch.last_index  = '0;
        in_ch.value       = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        hold_request      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // extremes, wrap-around and empty ranges
        send_item(CMD_QUERY, 0, LEAVES - 1, 32'h1234_5678);
        send_item(CMD_SET, 0, LEAVES - 1, 32'h7fff_ffff);
        send_item(CMD_SET, LEAVES - 1, 0, 32'h8000_0000);
        send_item(CMD_SET, 1, 'h2aa, 32'hffff_ffff);
        send_item(CMD_SET, 512, 'h155, 32'h0000_0001);
        send_item(CMD_QUERY, 0, LEAVES - 1, 32'hffff_ffff);
        send_item(CMD_QUERY, 0, 0, 32'h0);
        send_item(CMD_QUERY, LEAVES - 1, LEAVES - 1, 32'h0);
        send_item(CMD_QUERY, LEAVES - 1, 0, 32'h0);
        send_item(CMD_QUERY, 5, 4, 32'h0);
        send_item(CMD_QUERY, 0, 1, 32'h0);
        send_item(CMD_SET, 511, 0, 32'h7fff_ffff);
        send_item(CMD_SET, 512, 0, 32'h7fff_ffff);
        send_item(CMD_QUERY, 511, 512, 32'h0);
        send_item(CMD_QUERY, 1, LEAVES - 2, 32'h0);
        send_item(CMD_SET, 0, 0, 32'h0);
        send_item(CMD_QUERY, 0, LEAVES - 1, 32'h0);
        send_item(CMD_QUERY, 2, 2, 32'h0);

        // hold the output off while queries keep coming, so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 300;
        repeat (40) random_query();

        random_phase(348, 0, 0);
        random_phase(348, 56, 0);
        random_phase(348, 0, 56);
        random_phase(348, 29, 29);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (board.failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule

>>> range_sum_point_update_tree.f
hdl/rsput_pkg.sv
hdl/rsput_if.sv
hdl/rsput_ram.sv
hdl/rsput_engine.sv
hdl/range_sum_point_update_tree.sv
tb/tb.sv
